// ===== sv/annexb_pkg.sv =====
package annexb_pkg;

  localparam int HoldDepth = 4;
  localparam int WinDepth  = HoldDepth + 1;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  typedef logic [7:0] byte_t;
  typedef logic [2:0] wpos_t;   // position in the five-byte window, or a count 0..5

  localparam byte_t ZeroByte = 8'h00;
  localparam byte_t OneByte  = 8'h01;

  // One input item's results: window bytes plus per-byte flags, emitted range [beg, fin).
  typedef struct packed {
    byte_t [WinDepth-1:0] data;
    logic  [WinDepth-1:0] first;
    logic  [WinDepth-1:0] last;
    wpos_t                beg;
    wpos_t                fin;
  } burst_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== sv/annexb_front.sv =====
module annexb_front import annexb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [7:0] in_tdata,
  input  logic      in_tlast,
  input  q_status_t q_stat,
  output logic      push,
  output burst_t    push_burst
);

  byte_t               hold_r   [HoldDepth];
  byte_t               hold_nxt [HoldDepth];
  logic [HoldDepth-1:0] mark_r, mark_nxt;
  wpos_t               cnt_r, cnt_nxt;
  logic                inside_r, inside_nxt;

  byte_t               win [WinDepth];
  logic [WinDepth-1:0] wmark;
  logic [WinDepth-1:0] lastf;
  logic                accept;
  logic                sc;
  wpos_t               s;
  wpos_t               len;
  wpos_t               beg;
  wpos_t               fin;
  wpos_t               drop;
  wpos_t               j;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // window: held bytes, then the new byte
    for (int i = 0; i < HoldDepth; i++) begin
      if (3'(i) < cnt_r) begin
        win[i]   = hold_r[i];
        wmark[i] = mark_r[i];
      end else begin
        win[i]   = (3'(i) == cnt_r) ? in_tdata : ZeroByte;
        wmark[i] = 1'b0;
      end
    end
    win[HoldDepth]   = (cnt_r == 3'(HoldDepth)) ? in_tdata : ZeroByte;
    wmark[HoldDepth] = 1'b0;
    len = cnt_r + 3'd1;

    // 00 00 01 ending at the new byte; unit start moves back over one extra zero
    sc = 1'b0;
    s  = '0;
    unique case (cnt_r)
      3'd2: begin
        sc = (win[0] == ZeroByte) && (win[1] == ZeroByte) && (in_tdata == OneByte);
        s  = 3'd0;
      end
      3'd3: begin
        sc = (win[1] == ZeroByte) && (win[2] == ZeroByte) && (in_tdata == OneByte);
        s  = (win[0] == ZeroByte) ? 3'd0 : 3'd1;
      end
      3'd4: begin
        sc = (win[2] == ZeroByte) && (win[3] == ZeroByte) && (in_tdata == OneByte);
        s  = (win[1] == ZeroByte) ? 3'd1 : 3'd2;
      end
      default: begin
        sc = 1'b0;
        s  = '0;
      end
    endcase

    lastf = '0;
    beg   = '0;
    fin   = '0;
    drop  = '0;
    if (sc) begin
      wmark[s] = 1'b1;
      beg      = inside_r ? 3'd0 : s;
      fin      = in_tlast ? len : s;
      if (s != 3'd0) lastf[s - 3'd1] = 1'b1;
      if (in_tlast)  lastf[len - 3'd1] = 1'b1;
      drop     = s;
    end else if (!in_tlast && len == 3'(WinDepth)) begin
      // window full: oldest byte leaves
      fin  = inside_r ? 3'd1 : 3'd0;
      drop = 3'd1;
    end else if (in_tlast) begin
      fin = inside_r ? len : 3'd0;
      lastf[len - 3'd1] = 1'b1;
    end

    push            = accept && (fin > beg);
    push_burst.beg  = beg;
    push_burst.fin  = fin;
    push_burst.last = lastf;
    push_burst.first = wmark;
    for (int i = 0; i < WinDepth; i++) push_burst.data[i] = win[i];

    // next hold contents: window shifted down by drop
    for (int i = 0; i < HoldDepth; i++) begin
      j = 3'(i) + drop;
      if (j < 3'(WinDepth)) begin
        hold_nxt[i] = win[j];
        mark_nxt[i] = wmark[j];
      end else begin
        hold_nxt[i] = ZeroByte;
        mark_nxt[i] = 1'b0;
      end
    end

    cnt_nxt    = cnt_r;
    inside_nxt = inside_r;
    if (accept) begin
      if (in_tlast) begin
        cnt_nxt    = '0;
        inside_nxt = 1'b0;
      end else begin
        cnt_nxt    = len - drop;
        inside_nxt = inside_r || sc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      inside_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

// ===== sv/annexb_queue.sv =====
module annexb_queue import annexb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  burst_t    push_burst,
  input  logic      pop,
  output burst_t    head,
  output q_status_t q_stat
);

  burst_t           mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, wp_nxt;
  logic [QPtrW-1:0] rp_r, rp_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign head         = mem_r[rp_r];
  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == QCntW'(QDepth));

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == QPtrW'(QDepth - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == QPtrW'(QDepth - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_burst;
  end

endmodule

// ===== sv/annexb_back.sv =====
module annexb_back import annexb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_stat,
  input  burst_t     head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  wpos_t off_r, off_nxt;
  wpos_t cur;
  logic  end_hit;
  logic  xfer;

  always_comb begin
    cur        = head.beg + off_r;
    end_hit    = (cur + 3'd1) == head.fin;
    out_tvalid = q_stat.valid;
    out_tdata  = head.data[cur];
    out_tlast  = head.last[cur];
    out_tuser  = {end_hit, head.first[cur]};
    xfer       = out_tvalid && out_tready;
    pop        = xfer && end_hit;
    off_nxt    = off_r;
    if (xfer) off_nxt = end_hit ? 3'd0 : off_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) off_r <= '0;
    else        off_r <= off_nxt;
  end

endmodule

// ===== sv/annexb_nal_unit_splitter.sv =====
// Channel | Dir | tdata (low bit up) | tlast        | tuser (low bit up)
// in_     | in  | stream_byte[7:0]   | stream_end   | -
// out_    | out | unit_byte[7:0]     | unit_last    | unit_first, burst_last
//
// One input byte per cycle while in_tready is high; results are registered in the burst
// queue. A byte causing k results (k is 0..5) holds the output side for k items; the
// two-entry burst queue between classifier and serializer sets how far input runs ahead.
// rst_n is synchronous, active low; it empties the queue and forgets any open unit.
// in_tready drops only while the burst queue is full; out_tready may stall at any time.
module annexb_nal_unit_splitter import annexb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] stream_byte
  input  logic       in_tlast,   // stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] unit_byte
  output logic       out_tlast,  // unit_last
  output logic [1:0] out_tuser   // [0] unit_first, [1] burst_last
);

  q_status_t q_stat;
  logic      push;
  logic      pop;
  burst_t    push_burst;
  burst_t    head;

  // Front: holds up to four bytes, spots 00 00 01, builds the result burst per byte.
  annexb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_stat     (q_stat),
    .push       (push),
    .push_burst (push_burst)
  );

  // Bursts wait here so either side can stall without the other.
  annexb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // Back: walks the head burst one item per accepted output cycle.
  annexb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/annexb_checker.sv =====
module annexb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [1:0] out_tuser
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a unit is at least a start code long, so its first byte never ends it
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast)
    else $error("unit_first and unit_last on one item");

  // input backpressure only comes from pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with nothing to deliver");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output item changed");

endmodule

bind annexb_nal_unit_splitter annexb_checker u_chk (.*);
